// ===== hdl/tfe_pkg.sv =====
`default_nettype none
package tfe_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int SQRT_STEPS        = 32;
    localparam int DIV_STEPS         = 31;

    localparam logic [30:0]        ONE_Q30     = 31'd1073741824;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [32:0] HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [15:0] PI_OUT      = 16'sd25736;
    localparam logic [63:0]        ONE_Q60     = 64'd1 << 60;

    typedef enum logic [3:0] {
        OP_REDUCE,
        OP_ANGLE,
        OP_TRIGCLAMP,
        OP_P,
        OP_SQUARES,
        OP_DENSUM,
        OP_DIVPREP,
        OP_XCLAMP,
        OP_XMULS,
        OP_RXPREP,
        OP_ZMULS,
        OP_ZSUM,
        OP_ZSQ,
        OP_RZPREP,
        OP_VECPREP,
        OP_FINAL
    } op_t;

    typedef struct packed {
        logic signed [15:0] yaw_in;
        logic signed [14:0] a_in;
        logic signed [14:0] b_in;
        logic signed [16:0] yaw;
        logic               a_gt;
        logic               b_gt;
        logic               a_zero;
        logic               b_zero;
        logic [12:0]        ra;
        logic [12:0]        rb;
        logic signed [33:0] xa;
        logic signed [33:0] ya;
        logic signed [32:0] za;
        logic signed [33:0] xb;
        logic signed [33:0] yb;
        logic signed [32:0] zb;
        logic [30:0]        sa;
        logic [30:0]        ca;
        logic [30:0]        sb;
        logic [30:0]        cb;
        logic [30:0]        p;
        logic [61:0]        sq1;
        logic [61:0]        sq2;
        logic [63:0]        sqv;
        logic [63:0]        sqr;
        logic [30:0]        den;
        logic               degen;
        logic [60:0]        num;
        logic [31:0]        rem;
        logic [30:0]        quo;
        logic [30:0]        xq;
        logic [30:0]        yq;
        logic [30:0]        rx;
        logic [30:0]        zq;
        logic signed [15:0] dir;
        logic [13:0]        mag;
    } tfe_item_t;

    function automatic logic signed [32:0] atan_step(input int i);
        logic signed [32:0] v;
        begin
            v = '0;
            case (i)
                0:  v = 33'sd843314857;
                1:  v = 33'sd497837829;
                2:  v = 33'sd263043837;
                3:  v = 33'sd133525159;
                4:  v = 33'sd67021687;
                5:  v = 33'sd33543516;
                6:  v = 33'sd16775851;
                7:  v = 33'sd8388437;
                8:  v = 33'sd4194283;
                9:  v = 33'sd2097149;
                10: v = 33'sd1048576;
                default:
                begin
                    if (i <= 30)
                    begin
                        v = 33'(64'd1 << (30 - i));
                    end
                end
            endcase
            return v;
        end
    endfunction

    // Folds |a| mod 180 degrees into [0, 90] degrees; |sin| and |cos| are unchanged.
    function automatic logic [12:0] reduce_angle(input logic signed [14:0] a);
        logic [14:0] m;
        logic [14:0] r;
        begin
            m = a[14] ? (~a + 15'd1) : a;
            r = (m >= 15'd11520) ? (m - 15'd11520) : m;
            if (r > 15'd5760)
            begin
                r = 15'd11520 - r;
            end
            return r[12:0];
        end
    endfunction

    function automatic logic signed [32:0] to_q30(input logic [12:0] r);
        logic [41:0] t;
        begin
            t = 42'(r) * 42'd299845282 + 42'd512;
            return 33'(t >> 10);
        end
    endfunction

    function automatic logic [30:0] clamp_unit(input logic signed [33:0] v);
        logic [33:0] m;
        begin
            m = v[33] ? 34'(-v) : 34'(v);
            return (m > 34'(ONE_Q30)) ? ONE_Q30 : m[30:0];
        end
    endfunction

    function automatic logic [31:0] rnd_q30(input logic [61:0] prod);
        logic [62:0] t;
        begin
            t = 63'(prod) + (63'd1 << 29);
            return 32'(t >> 30);
        end
    endfunction

    function automatic logic [13:0] angle_out(input logic signed [32:0] z);
        logic signed [32:0] c;
        logic [33:0]        t;
        begin
            c = z;
            if (c < 0)
            begin
                c = '0;
            end
            if (c > HALF_PI_Q30)
            begin
                c = HALF_PI_Q30;
            end
            t = 34'(c) + 34'd65536;
            return 14'(t >> 17);
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/tfe_op_cell.sv =====
`default_nettype none
module tfe_op_cell #(
    parameter tfe_pkg::op_t OP = tfe_pkg::OP_REDUCE
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_vld,
    input  wire tfe_pkg::tfe_item_t d,
    output logic                    out_vld,
    output tfe_pkg::tfe_item_t      q
);
    import tfe_pkg::*;

    tfe_item_t item_reg;
    tfe_item_t item_next;
    logic      vld_reg;

    always_comb
    begin
        logic signed [16:0] ye;
        logic [16:0]        yabs;
        logic [34:0]        ymul;
        logic [18:0]        yrnd;
        logic [31:0]        zsum;
        logic [13:0]        ac;
        logic [30:0]        rxv;
        item_next = d;
        ye        = 17'(d.yaw_in);
        yabs      = ye[16] ? 17'(-ye) : 17'(ye);
        ymul      = 35'(yabs) * 35'd146409;
        yrnd      = 19'((ymul + 35'd32768) >> 16);
        zsum      = '0;
        ac        = '0;
        rxv       = d.sqr[30:0];
        unique case (OP)
            OP_REDUCE:
            begin
                if (!ye[16])
                begin
                    item_next.yaw = (yrnd > 19'd65535) ? 17'sd65535 : 17'(yrnd);
                end
                else
                begin
                    item_next.yaw = (yrnd > 19'd65536) ? -17'sd65536
                                                       : 17'(~yrnd[16:0] + 17'd1);
                end
                item_next.a_gt   = !d.a_in[14] && (d.a_in != '0);
                item_next.b_gt   = !d.b_in[14] && (d.b_in != '0);
                item_next.ra     = reduce_angle(d.a_in);
                item_next.rb     = reduce_angle(d.b_in);
                item_next.a_zero = (reduce_angle(d.a_in) == '0);
                item_next.b_zero = (reduce_angle(d.b_in) == '0);
            end
            OP_ANGLE:
            begin
                item_next.xa = GAIN_Q30;
                item_next.ya = '0;
                item_next.za = to_q30(d.ra);
                item_next.xb = GAIN_Q30;
                item_next.yb = '0;
                item_next.zb = to_q30(d.rb);
            end
            OP_TRIGCLAMP:
            begin
                item_next.sa = d.a_zero ? '0 : clamp_unit(d.ya);
                item_next.ca = d.a_zero ? ONE_Q30 : clamp_unit(d.xa);
                item_next.sb = d.b_zero ? '0 : clamp_unit(d.yb);
                item_next.cb = d.b_zero ? ONE_Q30 : clamp_unit(d.xb);
            end
            OP_P:
            begin
                item_next.p = 31'(rnd_q30(62'(d.sa) * 62'(d.cb)));
            end
            OP_SQUARES:
            begin
                item_next.sq1 = 62'(d.p) * 62'(d.p);
                item_next.sq2 = 62'(d.sb) * 62'(d.sb);
            end
            OP_DENSUM:
            begin
                item_next.sqv = 64'(d.sq1) + 64'(d.sq2);
                item_next.sqr = '0;
            end
            OP_DIVPREP:
            begin
                item_next.den   = d.sqr[30:0];
                item_next.degen = (d.sqr == '0);
                item_next.num   = {d.sb, 30'd0} + 61'(d.sqr[30:1]);
                item_next.rem   = 32'(item_next.num >> 31);
                item_next.quo   = '0;
            end
            OP_XCLAMP:
            begin
                item_next.xq = (d.quo > ONE_Q30) ? ONE_Q30 : d.quo;
            end
            OP_XMULS:
            begin
                item_next.yq  = 31'(rnd_q30(62'(d.xq) * 62'(d.sb)));
                item_next.sq1 = 62'(d.xq) * 62'(d.xq);
            end
            OP_RXPREP:
            begin
                item_next.sqv = ONE_Q60 - 64'(d.sq1);
                item_next.sqr = '0;
            end
            OP_ZMULS:
            begin
                item_next.rx  = rxv;
                item_next.sq1 = 62'(d.yq) * 62'(d.ca);
                item_next.sq2 = 62'(rxv) * 62'(d.sa);
            end
            OP_ZSUM:
            begin
                zsum = rnd_q30(d.sq1) + rnd_q30(d.sq2);
                item_next.zq = (zsum > 32'(ONE_Q30)) ? ONE_Q30 : zsum[30:0];
            end
            OP_ZSQ:
            begin
                item_next.sq1 = 62'(d.zq) * 62'(d.zq);
            end
            OP_RZPREP:
            begin
                item_next.sqv = ONE_Q60 - 64'(d.sq1);
                item_next.sqr = '0;
            end
            OP_VECPREP:
            begin
                // Lane A works out acos(x), lane B asin(z).
                item_next.xa = 34'(d.xq);
                item_next.ya = 34'(d.rx);
                item_next.za = '0;
                item_next.xb = 34'(rxv);
                item_next.yb = 34'(d.zq);
                item_next.zb = '0;
            end
            OP_FINAL:
            begin
                ac = angle_out(d.za);
                if (d.degen)
                begin
                    item_next.dir = '0;
                    item_next.mag = '0;
                end
                else
                begin
                    item_next.mag = angle_out(d.zb);
                    if (!d.a_gt && !d.b_gt)
                    begin
                        item_next.dir = 16'(ac);
                    end
                    else if (!d.a_gt)
                    begin
                        item_next.dir = PI_OUT - 16'(ac);
                    end
                    else if (d.b_gt)
                    begin
                        item_next.dir = 16'(ac) - PI_OUT;
                    end
                    else
                    begin
                        item_next.dir = -16'(ac);
                    end
                end
            end
            default:
            begin
                item_next = d;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_vld = vld_reg;
    assign q       = item_reg;

endmodule
`default_nettype wire

// ===== hdl/tfe_cordic_cell.sv =====
`default_nettype none
module tfe_cordic_cell #(
    parameter int   STEP = 0,
    parameter logic VEC  = 1'b0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_vld,
    input  wire tfe_pkg::tfe_item_t d,
    output logic                    out_vld,
    output tfe_pkg::tfe_item_t      q
);
    import tfe_pkg::*;

    tfe_item_t item_reg;
    tfe_item_t item_next;
    logic      vld_reg;

    always_comb
    begin
        logic signed [32:0] at;
        logic               up_a;
        logic               up_b;
        at        = atan_step(STEP);
        item_next = d;
        // Rotation follows the sign of the residual angle, vectoring that of y.
        up_a = VEC ? !d.ya[33] : !d.za[32];
        up_b = VEC ? !d.yb[33] : !d.zb[32];
        if (up_a ^ VEC)
        begin
            item_next.xa = d.xa - (d.ya >>> STEP);
            item_next.ya = d.ya + (d.xa >>> STEP);
        end
        else
        begin
            item_next.xa = d.xa + (d.ya >>> STEP);
            item_next.ya = d.ya - (d.xa >>> STEP);
        end
        item_next.za = (up_a ^ VEC) ? (d.za - at) : (d.za + at);
        if (up_b ^ VEC)
        begin
            item_next.xb = d.xb - (d.yb >>> STEP);
            item_next.yb = d.yb + (d.xb >>> STEP);
        end
        else
        begin
            item_next.xb = d.xb + (d.yb >>> STEP);
            item_next.yb = d.yb - (d.xb >>> STEP);
        end
        item_next.zb = (up_b ^ VEC) ? (d.zb - at) : (d.zb + at);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_vld = vld_reg;
    assign q       = item_reg;

endmodule
`default_nettype wire

// ===== hdl/tfe_sqrt_cell.sv =====
`default_nettype none
module tfe_sqrt_cell #(
    parameter int STEP = 0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_vld,
    input  wire tfe_pkg::tfe_item_t d,
    output logic                    out_vld,
    output tfe_pkg::tfe_item_t      q
);
    import tfe_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    tfe_item_t item_reg;
    tfe_item_t item_next;
    logic      vld_reg;

    always_comb
    begin
        item_next = d;
        if (d.sqv >= d.sqr + BIT)
        begin
            item_next.sqv = d.sqv - (d.sqr + BIT);
            item_next.sqr = (d.sqr >> 1) + BIT;
        end
        else
        begin
            item_next.sqr = d.sqr >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_vld = vld_reg;
    assign q       = item_reg;

endmodule
`default_nettype wire

// ===== hdl/tfe_div_cell.sv =====
`default_nettype none
module tfe_div_cell #(
    parameter int STEP = 0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_vld,
    input  wire tfe_pkg::tfe_item_t d,
    output logic                    out_vld,
    output tfe_pkg::tfe_item_t      q
);
    import tfe_pkg::*;

    localparam int NBIT = DIV_STEPS - 1 - STEP;

    tfe_item_t item_reg;
    tfe_item_t item_next;
    logic      vld_reg;

    always_comb
    begin
        logic [31:0] t;
        logic        ge;
        t         = {d.rem[30:0], d.num[NBIT]};
        ge        = (t >= {1'b0, d.den});
        item_next = d;
        item_next.rem = ge ? (t - {1'b0, d.den}) : t;
        item_next.quo = {d.quo[29:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_vld = vld_reg;
    assign q       = item_reg;

endmodule
`default_nettype wire

// ===== hdl/tilt_from_euler_angles_unit.sv =====
// Channel   Dir  Payload
// s_axis    in   s_tdata[15:0] yaw_deg, [30:16] angle_a_deg, [45:31] angle_b_deg
// m_axis    out  m_tdata[16:0] yaw_rad, [32:17] tilt_direction, [46:33] tilt_magnitude;
//                m_tuser degenerate
//
// One word is accepted every cycle unless the chain holds; each word passes through
// the chain of CORDIC, square root, divider and operation cells.
// Reset clears only the valid bits of the chain.
// When a result waits and m_tready is low the whole chain holds, and s_tready is low.
`default_nettype none
module tilt_from_euler_angles_unit #(
    parameter int CORDIC_STAGES = tfe_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // yaw_deg, angle_a_deg, angle_b_deg, zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // yaw_rad, tilt_direction, tilt_magnitude, zero pad
    output logic             m_tuser    // degenerate
);
    import tfe_pkg::*;

    localparam int N      = CORDIC_STAGES;
    localparam int K_ROT  = 2;
    localparam int K_TCL  = K_ROT + N;
    localparam int K_DSUM = K_TCL + 3;
    localparam int K_SQ1  = K_DSUM + 1;
    localparam int K_DPRE = K_SQ1 + SQRT_STEPS;
    localparam int K_DIV  = K_DPRE + 1;
    localparam int K_XCL  = K_DIV + DIV_STEPS;
    localparam int K_SQ2  = K_XCL + 3;
    localparam int K_ZMUL = K_SQ2 + SQRT_STEPS;
    localparam int K_SQ3  = K_ZMUL + 4;
    localparam int K_VPRE = K_SQ3 + SQRT_STEPS;
    localparam int K_VEC  = K_VPRE + 1;
    localparam int K_FIN  = K_VEC + N;
    localparam int TOTAL  = K_FIN + 1;

    function automatic op_t op_at(input int k);
        op_t o;
        begin
            if (k == 0)                o = OP_REDUCE;
            else if (k == 1)           o = OP_ANGLE;
            else if (k == K_TCL)       o = OP_TRIGCLAMP;
            else if (k == K_TCL + 1)   o = OP_P;
            else if (k == K_TCL + 2)   o = OP_SQUARES;
            else if (k == K_DSUM)      o = OP_DENSUM;
            else if (k == K_DPRE)      o = OP_DIVPREP;
            else if (k == K_XCL)       o = OP_XCLAMP;
            else if (k == K_XCL + 1)   o = OP_XMULS;
            else if (k == K_XCL + 2)   o = OP_RXPREP;
            else if (k == K_ZMUL)      o = OP_ZMULS;
            else if (k == K_ZMUL + 1)  o = OP_ZSUM;
            else if (k == K_ZMUL + 2)  o = OP_ZSQ;
            else if (k == K_ZMUL + 3)  o = OP_RZPREP;
            else if (k == K_VPRE)      o = OP_VECPREP;
            else                       o = OP_FINAL;
            return o;
        end
    endfunction

    tfe_item_t itm [0:TOTAL];
    logic      vld [0:TOTAL];
    logic      en;

    assign en       = !vld[TOTAL] || m_tready;
    assign s_tready = en;

    always_comb
    begin
        itm[0]        = '0;
        itm[0].yaw_in = s_tdata[15:0];
        itm[0].a_in   = s_tdata[30:16];
        itm[0].b_in   = s_tdata[45:31];
    end
    assign vld[0] = s_tvalid;

    for (genvar k = 0; k < TOTAL; k++)
    begin : g_st
        if (k >= K_ROT && k < K_ROT + N)
        begin : g_rot
            tfe_cordic_cell #(.STEP(k - K_ROT), .VEC(1'b0)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld[k]), .d(itm[k]),
                .out_vld(vld[k + 1]), .q(itm[k + 1]));
        end
        else if (k >= K_VEC && k < K_VEC + N)
        begin : g_vec
            tfe_cordic_cell #(.STEP(k - K_VEC), .VEC(1'b1)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld[k]), .d(itm[k]),
                .out_vld(vld[k + 1]), .q(itm[k + 1]));
        end
        else if (k >= K_SQ1 && k < K_SQ1 + SQRT_STEPS)
        begin : g_sq1
            tfe_sqrt_cell #(.STEP(k - K_SQ1)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld[k]), .d(itm[k]),
                .out_vld(vld[k + 1]), .q(itm[k + 1]));
        end
        else if (k >= K_SQ2 && k < K_SQ2 + SQRT_STEPS)
        begin : g_sq2
            tfe_sqrt_cell #(.STEP(k - K_SQ2)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld[k]), .d(itm[k]),
                .out_vld(vld[k + 1]), .q(itm[k + 1]));
        end
        else if (k >= K_SQ3 && k < K_SQ3 + SQRT_STEPS)
        begin : g_sq3
            tfe_sqrt_cell #(.STEP(k - K_SQ3)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld[k]), .d(itm[k]),
                .out_vld(vld[k + 1]), .q(itm[k + 1]));
        end
        else if (k >= K_DIV && k < K_DIV + DIV_STEPS)
        begin : g_div
            tfe_div_cell #(.STEP(k - K_DIV)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld[k]), .d(itm[k]),
                .out_vld(vld[k + 1]), .q(itm[k + 1]));
        end
        else
        begin : g_op
            tfe_op_cell #(.OP(op_at(k))) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld[k]), .d(itm[k]),
                .out_vld(vld[k + 1]), .q(itm[k + 1]));
        end
    end

    assign m_tvalid = vld[TOTAL];
    assign m_tdata  = {1'b0, itm[TOTAL].mag, itm[TOTAL].dir, itm[TOTAL].yaw};
    assign m_tuser  = itm[TOTAL].degen;

endmodule
`default_nettype wire
